### rtl/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types, constants and helpers for the pixel channel adjust block.
// ----------------------------------------------------------------------------
package pca_pkg;

  // Pixel geometry
  localparam int NUM_CH      = 3;            // red, green, blue
  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 32;
  localparam int CH_W        = 2;

  // Look-up tables
  localparam int LUT_DEPTH   = 256;
  localparam int LUT_ADDR_W  = $clog2(LUT_DEPTH);

  // Brightness and contrast arithmetic
  localparam int BV_W            = 9;        // signed brightness value
  localparam int GAIN_W          = 16;       // unsigned gain
  localparam int GAIN_FRAC_BITS  = 12;
  localparam int DIFF_W          = BYTE_W + 1;
  localparam int PROD_W          = DIFF_W + GAIN_W + 1;
  localparam int QUOT_W          = PROD_W - GAIN_FRAC_BITS;

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_ENABLES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_CHANNEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_VALUES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_GAINS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GREY_LEVEL        = 3'd6;

  // Stage enable bits
  localparam int EN_LUT    = 0;
  localparam int EN_BRIGHT = 1;
  localparam int EN_CONTR  = 2;
  localparam int EN_KEEP   = 3;

  // Brightness mask bit for alpha
  localparam int MASK_ALPHA = 3;

  // Brightness modes
  localparam logic [1:0] BMODE_NONE = 2'd0;
  localparam logic [1:0] BMODE_ABS  = 2'd1;
  localparam logic [1:0] BMODE_REL  = 2'd2;

  // Opcodes
  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_LUT_WRITE = 1'b1;

  // Register reset values
  localparam logic [NUM_CH*GAIN_W-1:0] GAINS_RESET = 48'h1000_1000_1000;
  localparam logic [BYTE_W-1:0]        GREY_RESET  = 8'd128;

  typedef struct packed {
    logic [3:0]             stage_enables;
    logic [CH_W-1:0]        keep_channel;
    logic [3:0]             brightness_mask;
    logic [1:0]             brightness_mode;
    logic [4*BV_W-1:0]      brightness_values;
    logic [NUM_CH*GAIN_W-1:0] contrast_gains;
    logic [BYTE_W-1:0]      grey_level;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]             alpha;
    logic [NUM_CH-1:0][BYTE_W-1:0] col;   // index 0 red, 1 green, 2 blue
    logic                          eof;
  } pix_t;

  // Color channels that take part in the adjustment stages
  function automatic logic [NUM_CH-1:0] active_mask(input cfg_t c);
    logic [NUM_CH-1:0] m;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      m[ch] = !c.stage_enables[EN_KEEP] || (c.keep_channel == CH_W'(ch));
    end
    return m;
  endfunction

endpackage

### rtl/pixel_channel_adjust.sv
// ----------------------------------------------------------------------------
// pixel_channel_adjust
// Per-pixel point operation on ARGB pixels: LUT, brightness, contrast, keep.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_ready is high: either a pixel
// or a write of one byte into the red, green or blue look-up table. A pixel
// passes four register stages in order (LUT read, brightness, contrast
// multiply, floor/clamp/keep) and appears on pixel_out from the last one; the
// pipeline sustains one pixel per cycle as long as the output side takes
// them. A stall holds each full stage in place while empty stages still fill.
// A LUT write completes at the edge that accepts it and produces no output
// item. LUT entries must be written before any pixel reads them. The user
// must write configuration registers through the cfg port only while no
// pixel is in flight (not enforced by the block); the port is always ready.
module pixel_channel_adjust (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pca_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Input item channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 opcode,
  input  logic [pca_pkg::PIX_W-1:0]            pixel_in,
  input  logic                                 end_of_frame,
  input  logic [pca_pkg::CH_W-1:0]             lut_channel,
  input  logic [pca_pkg::LUT_ADDR_W-1:0]       lut_index,
  input  logic [pca_pkg::BYTE_W-1:0]           lut_value,
  // Output item channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pca_pkg::PIX_W-1:0]            pixel_out,
  output logic                                 end_of_frame_out
);
  import pca_pkg::*;

  cfg_t                          cfg;
  logic                          rd_valid;
  logic                          rd_en;
  logic                          accept;
  pix_t                          rd_item;
  logic [NUM_CH-1:0][BYTE_W-1:0] lut_q;
  logic                          br_ready;
  logic                          br_valid;
  pix_t                          br_item;
  logic                          ct_ready;
  pix_t                          res_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stage_enables     <= '0;
      cfg.keep_channel      <= '0;
      cfg.brightness_mask   <= '0;
      cfg.brightness_mode   <= BMODE_NONE;
      cfg.brightness_values <= '0;
      cfg.contrast_gains    <= GAINS_RESET;
      cfg.grey_level        <= GREY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STAGE_ENABLES:     cfg.stage_enables     <= cfg_data[3:0];
        REG_KEEP_CHANNEL:      cfg.keep_channel      <= cfg_data[CH_W-1:0];
        REG_BRIGHTNESS_MASK:   cfg.brightness_mask   <= cfg_data[3:0];
        REG_BRIGHTNESS_MODE:   cfg.brightness_mode   <= cfg_data[1:0];
        REG_BRIGHTNESS_VALUES: cfg.brightness_values <= cfg_data[4*BV_W-1:0];
        REG_CONTRAST_GAINS:    cfg.contrast_gains    <= cfg_data[NUM_CH*GAIN_W-1:0];
        REG_GREY_LEVEL:        cfg.grey_level        <= cfg_data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // LUT read stage handshake
  assign rd_en    = !rd_valid || br_ready;
  assign in_ready = rd_en;
  assign accept   = in_valid && rd_en;

  // One table per color, written by LUT items and read by pixels
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lut
    logic                  we;
    logic [LUT_ADDR_W-1:0] addr;
    assign we   = accept && opcode == OP_LUT_WRITE && lut_channel == CH_W'(g);
    assign addr = (opcode == OP_LUT_WRITE) ? lut_index
                                           : pixel_in[BYTE_W*(NUM_CH-1-g) +: BYTE_W];
    pca_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LUT_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .re    (rd_en),
      .addr  (addr),
      .wdata (lut_value),
      .rdata (lut_q[g])
    );
  end

  // Advance the read stage valid bit; only pixels make results
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= in_valid && opcode == OP_PIXEL;
    end
  end

  // Hold the pixel alongside the table read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_item.alpha <= pixel_in[PIX_W-1 -: BYTE_W];
      for (int ch = 0; ch < NUM_CH; ch++) begin
        rd_item.col[ch] <= pixel_in[BYTE_W*(NUM_CH-1-ch) +: BYTE_W];
      end
      rd_item.eof <= end_of_frame;
    end
  end

  pca_bright u_bright (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (rd_valid),
    .up_ready (br_ready),
    .up_item  (rd_item),
    .lut_q    (lut_q),
    .dn_valid (br_valid),
    .dn_ready (ct_ready),
    .dn_item  (br_item)
  );

  pca_contrast u_contrast (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (br_valid),
    .up_ready  (ct_ready),
    .up_item   (br_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (res_item)
  );

  // Repack the result in ARGB byte order
  assign pixel_out        = {res_item.alpha, res_item.col[0], res_item.col[1], res_item.col[2]};
  assign end_of_frame_out = res_item.eof;

endmodule

### rtl/pca_ram.sv
// ----------------------------------------------------------------------------
// pca_ram
// Generic single-port RAM with registered read data and read enable.
// ----------------------------------------------------------------------------
module pca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/pca_bright.sv
// ----------------------------------------------------------------------------
// pca_bright
// Pipeline stage: select LUT-mapped colors, then apply brightness.
// ----------------------------------------------------------------------------
module pca_bright (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pca_pkg::cfg_t                           cfg,
  input  logic                                    up_valid,
  output logic                                    up_ready,
  input  pca_pkg::pix_t                           up_item,
  input  logic [pca_pkg::NUM_CH-1:0][pca_pkg::BYTE_W-1:0] lut_q,
  output logic                                    dn_valid,
  input  logic                                    dn_ready,
  output pca_pkg::pix_t                           dn_item
);
  import pca_pkg::*;

  logic              valid;
  logic              en;
  pix_t              item_next;
  logic [NUM_CH-1:0] active;
  logic              bright_on;

  // Apply one brightness value to a byte
  function automatic logic [BYTE_W-1:0] bright(input logic [BYTE_W-1:0] c,
                                               input logic [BV_W-1:0] v,
                                               input logic [1:0] mode);
    logic signed [BV_W:0] sum;
    logic [BYTE_W-1:0]    res;
    sum = $signed({2'b00, c}) + $signed({v[BV_W-1], v});
    if (mode == BMODE_ABS) begin
      res = v[BYTE_W-1:0];
    end else if (sum < 0) begin
      res = '0;
    end else if (sum > $signed((BV_W+1)'(255))) begin
      res = '1;
    end else begin
      res = sum[BYTE_W-1:0];
    end
    return res;
  endfunction

  assign en       = !valid || dn_ready;
  assign up_ready = en;
  assign dn_valid = valid;

  assign active    = active_mask(cfg);
  assign bright_on = cfg.stage_enables[EN_BRIGHT] &&
                     (cfg.brightness_mode == BMODE_ABS || cfg.brightness_mode == BMODE_REL);

  // Map and brighten each channel
  always_comb begin
    item_next = up_item;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (cfg.stage_enables[EN_LUT] && active[ch]) begin
        item_next.col[ch] = lut_q[ch];
      end
      if (bright_on && active[ch] && cfg.brightness_mask[ch]) begin
        item_next.col[ch] = bright(item_next.col[ch], cfg.brightness_values[BV_W*ch +: BV_W],
                                   cfg.brightness_mode);
      end
    end
    if (bright_on && cfg.brightness_mask[MASK_ALPHA]) begin
      item_next.alpha = bright(up_item.alpha, cfg.brightness_values[BV_W*NUM_CH +: BV_W],
                               cfg.brightness_mode);
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      dn_item <= item_next;
    end
  end

endmodule

### rtl/pca_contrast.sv
// ----------------------------------------------------------------------------
// pca_contrast
// Two pipeline stages: contrast product, then floor, pivot, clamp and keep.
// ----------------------------------------------------------------------------
module pca_contrast (
  input  logic          clk,
  input  logic          rst,
  input  pca_pkg::cfg_t cfg,
  input  logic          up_valid,
  output logic          up_ready,
  input  pca_pkg::pix_t up_item,
  output logic          out_valid,
  input  logic          out_ready,
  output pca_pkg::pix_t out_item
);
  import pca_pkg::*;

  logic                     prod_valid;
  logic                     prod_en;
  logic                     out_en;
  pix_t                     prod_item;
  logic [NUM_CH-1:0]        apply;
  logic [NUM_CH-1:0]        apply_next;
  logic signed [PROD_W-1:0] prod      [NUM_CH];
  logic signed [PROD_W-1:0] prod_next [NUM_CH];
  pix_t                     out_next;
  logic [NUM_CH-1:0]        active;

  assign out_en    = !out_valid || out_ready;
  assign prod_en   = !prod_valid || out_en;
  assign up_ready  = prod_en;
  assign active    = active_mask(cfg);

  // Multiply the offset from grey by each channel gain
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      logic signed [DIFF_W-1:0] diff;
      diff = $signed({1'b0, up_item.col[ch]}) - $signed({1'b0, cfg.grey_level});
      prod_next[ch]  = PROD_W'(diff) *
                       PROD_W'($signed({1'b0, cfg.contrast_gains[GAIN_W*ch +: GAIN_W]}));
      apply_next[ch] = cfg.stage_enables[EN_CONTR] && active[ch];
    end
  end

  // Floor, add the pivot back, clamp, then zero the colors not kept
  always_comb begin
    out_next = prod_item;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      logic signed [QUOT_W-1:0] quot;
      logic signed [QUOT_W:0]   sum;
      quot = QUOT_W'(prod[ch] >>> GAIN_FRAC_BITS);
      sum  = $signed({quot[QUOT_W-1], quot}) +
             $signed({{(QUOT_W+1-BYTE_W){1'b0}}, cfg.grey_level});
      if (apply[ch]) begin
        if (sum < 0) begin
          out_next.col[ch] = '0;
        end else if (sum > $signed((QUOT_W+1)'(255))) begin
          out_next.col[ch] = '1;
        end else begin
          out_next.col[ch] = sum[BYTE_W-1:0];
        end
      end
      if (cfg.stage_enables[EN_KEEP] && cfg.keep_channel < CH_W'(NUM_CH) &&
          cfg.keep_channel != CH_W'(ch)) begin
        out_next.col[ch] = '0;
      end
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_valid <= up_valid;
      end
      if (out_en) begin
        out_valid <= prod_valid;
      end
    end
  end

  // Product stage payload
  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_item <= up_item;
      apply     <= apply_next;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        prod[ch] <= prod_next[ch];
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_en) begin
      out_item <= out_next;
    end
  end

endmodule
